// ----- design/ircfd_pkg.sv -----
package ircfd_pkg;

  localparam int FRAME_BYTES = 21;

  // item positions after the header pair
  localparam int DIV_A_POS = 6 * 8;
  localparam int DIV_B_POS = 14 * 8 + 1;
  localparam int LAST_ITEM = FRAME_BYTES * 8 + 2;

  localparam int BOUND_W = 21;
  localparam int SCALED_W = 23;

  // nominal durations in microseconds
  localparam int NUM_NOM = 6;
  localparam int NOM_HDR_MARK = 0;
  localparam int NOM_HDR_SPACE = 1;
  localparam int NOM_BIT_MARK = 2;
  localparam int NOM_ONE_SPACE = 3;
  localparam int NOM_ZERO_SPACE = 4;
  localparam int NOM_DIV_SPACE = 5;

  localparam logic [13:0] NOMINAL [NUM_NOM] = '{
    14'd9000, 14'd4494, 14'd572, 14'd1659, 14'd553, 14'd7960
  };

  localparam logic [6:0] TOL_RESET = 7'd25;
  localparam logic [5:0] MIN_TEMP_RESET = 6'd18;

  localparam logic [7:0] REMOTE_ID0 = 8'h83;
  localparam logic [7:0] REMOTE_ID1 = 8'h06;
  localparam logic [7:0] SWING_BYTE = 8'h40;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MIN_TEMP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HDR_FAIL = 3'd1,
    ST_BIT_FAIL = 3'd2,
    ST_FTR_FAIL = 3'd3,
    ST_SUM_FAIL = 3'd4,
    ST_ID_FAIL  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_HEAT_COOL = 3'd1,
    MODE_HEAT      = 3'd2,
    MODE_COOL      = 3'd3,
    MODE_DRY       = 3'd4,
    MODE_FAN_ONLY  = 3'd5
  } mode_e;

  // bounds kept scaled by 100 so that the match needs no division
  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } bound_t;

  function automatic bound_t make_bound(logic [6:0] tol, logic [13:0] nom);
    bound_t b;
    logic [BOUND_W-1:0] n;
    n = BOUND_W'(nom);
    if (tol >= 7'd100) begin
      b.lo = '0;
    end else begin
      b.lo = BOUND_W'((BOUND_W'(100) - BOUND_W'(tol)) * n);
    end
    b.hi = BOUND_W'((BOUND_W'(100) + BOUND_W'(tol)) * n);
    return b;
  endfunction

  // floor(lo/100) <= meas <= floor(hi/100)
  function automatic logic near(logic [SCALED_W-1:0] m100, bound_t b);
    logic [SCALED_W-1:0] m100_top;
    m100_top = m100 + SCALED_W'(99);
    return (SCALED_W'(b.lo) <= m100_top) && (m100 <= SCALED_W'(b.hi));
  endfunction

endpackage

// ----- design/ir_climate_frame_decoder_unit.sv -----
// path: input register, combinational decode step, then result register; only a frame end
// or a failure writes a result word; throughput: one word per cycle while the result
// register is free or being read out
// reset: frame idle, checksums, mode, power and swing cleared, tolerance 25, minimum
// temperature 18; the captured frame bytes are not reset
module ir_climate_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mark_us[15:0], space_us[31:16]
  input  logic [0:0]  s_axis_tuser,  // capture_start[0]
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // hvac_mode[2:0], target_temp[9:3], fan_speed[11:10],
                                     // swing_on[12], power_assumed[13], zero[15:14]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [6:0] tol_q;
  logic [5:0] min_temp_q;
  ircfd_pkg::bound_t bound_q [ircfd_pkg::NUM_NOM];
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == ircfd_pkg::REG_MIN_TEMP) ? {26'd0, min_temp_q}
                                                        : {25'd0, tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ircfd_pkg::TOL_RESET;
      min_temp_q <= ircfd_pkg::MIN_TEMP_RESET;
      for (int k = 0; k < ircfd_pkg::NUM_NOM; k++) begin
        bound_q[k] <= ircfd_pkg::make_bound(ircfd_pkg::TOL_RESET, ircfd_pkg::NOMINAL[k]);
      end
    end else if (cfg_wr) begin
      if (paddr[2] == ircfd_pkg::REG_TOLERANCE) begin
        tol_q <= pwdata[6:0];
        for (int k = 0; k < ircfd_pkg::NUM_NOM; k++) begin
          bound_q[k] <= ircfd_pkg::make_bound(pwdata[6:0], ircfd_pkg::NOMINAL[k]);
        end
      end else begin
        min_temp_q <= pwdata[5:0];
      end
    end
  end

  // input register
  logic        in_valid_q;
  logic [15:0] mark_q;
  logic [15:0] space_q;
  logic        start_q;
  logic        fire;
  logic        res_valid;

  assign fire = in_valid_q & (~res_valid | ~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mark_q <= s_axis_tdata[15:0];
      space_q <= s_axis_tdata[31:16];
      start_q <= s_axis_tuser[0];
    end
  end

  // duration matching
  logic [ircfd_pkg::SCALED_W-1:0] mark100;
  logic [ircfd_pkg::SCALED_W-1:0] space100;
  logic hdr_mark_ok, hdr_space_ok, bit_mark_ok, one_ok, zero_ok, div_ok;

  assign mark100 = (ircfd_pkg::SCALED_W'(mark_q) << 6) + (ircfd_pkg::SCALED_W'(mark_q) << 5)
                 + (ircfd_pkg::SCALED_W'(mark_q) << 2);
  assign space100 = (ircfd_pkg::SCALED_W'(space_q) << 6)
                  + (ircfd_pkg::SCALED_W'(space_q) << 5)
                  + (ircfd_pkg::SCALED_W'(space_q) << 2);

  assign hdr_mark_ok = ircfd_pkg::near(mark100, bound_q[ircfd_pkg::NOM_HDR_MARK]);
  assign hdr_space_ok = ircfd_pkg::near(space100, bound_q[ircfd_pkg::NOM_HDR_SPACE]);
  assign bit_mark_ok = ircfd_pkg::near(mark100, bound_q[ircfd_pkg::NOM_BIT_MARK]);
  assign one_ok = ircfd_pkg::near(space100, bound_q[ircfd_pkg::NOM_ONE_SPACE]);
  assign zero_ok = ircfd_pkg::near(space100, bound_q[ircfd_pkg::NOM_ZERO_SPACE]);
  assign div_ok = ircfd_pkg::near(space100, bound_q[ircfd_pkg::NOM_DIV_SPACE]);

  // frame state
  logic [8:0] phase_q, phase_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] xor_lo_q, xor_lo_d;
  logic [7:0] xor_hi_q, xor_hi_d;
  logic [7:0] b0_q, b0_d, b1_q, b1_d, b2_q, b2_d, b3_q, b3_d;
  logic [7:0] b8_q, b8_d, b13_q, b13_d, b20_q, b20_d;
  ircfd_pkg::mode_e mode_q, mode_d;
  logic power_q, power_d;
  logic swing_q, swing_d;

  logic [8:0] pos;
  logic [7:0] bit_num;
  logic [4:0] byte_idx;
  logic [2:0] bit_idx;
  logic       bit_val;
  logic [7:0] acc_new;
  ircfd_pkg::status_e res_status;
  logic [6:0] res_temp;
  logic [1:0] res_fan;

  assign pos = phase_q - 9'd1;

  always_comb begin
    if (pos < 9'(ircfd_pkg::DIV_A_POS)) begin
      bit_num = pos[7:0];
    end else if (pos < 9'(ircfd_pkg::DIV_B_POS)) begin
      bit_num = 8'(pos - 9'd1);
    end else begin
      bit_num = 8'(pos - 9'd2);
    end
  end

  assign byte_idx = bit_num[7:3];
  assign bit_idx = bit_num[2:0];
  assign bit_val = one_ok;
  assign acc_new = ((bit_idx == 3'd0) ? 8'h00 : acc_q) | (8'(bit_val) << bit_idx);

  always_comb begin
    phase_d = phase_q;
    acc_d = acc_q;
    xor_lo_d = xor_lo_q;
    xor_hi_d = xor_hi_q;
    b0_d = b0_q;
    b1_d = b1_q;
    b2_d = b2_q;
    b3_d = b3_q;
    b8_d = b8_q;
    b13_d = b13_q;
    b20_d = b20_q;
    mode_d = mode_q;
    power_d = power_q;
    swing_d = swing_q;
    res_valid = 1'b0;
    res_status = ircfd_pkg::ST_OK;
    res_temp = '0;
    res_fan = '0;

    if (start_q) begin
      if (!(hdr_mark_ok && hdr_space_ok)) begin
        res_valid = 1'b1;
        res_status = ircfd_pkg::ST_HDR_FAIL;
        phase_d = '0;
      end else begin
        xor_lo_d = '0;
        xor_hi_d = '0;
        phase_d = 9'd1;
      end
    end else if (phase_q == 9'd0 || phase_q > 9'(ircfd_pkg::LAST_ITEM + 1)) begin
      phase_d = '0;
    end else if (pos >= 9'(ircfd_pkg::LAST_ITEM)) begin
      // footer mark closes the frame
      res_valid = 1'b1;
      phase_d = '0;
      if (!bit_mark_ok) begin
        res_status = ircfd_pkg::ST_FTR_FAIL;
      end else if (xor_lo_q != b13_q || xor_hi_q != b20_q) begin
        res_status = ircfd_pkg::ST_SUM_FAIL;
      end else if (b0_q != ircfd_pkg::REMOTE_ID0 || b1_q != ircfd_pkg::REMOTE_ID1) begin
        res_status = ircfd_pkg::ST_ID_FAIL;
      end else begin
        // power toggle
        if (b2_q[2]) begin
          if (mode_q != ircfd_pkg::MODE_OFF) begin
            mode_d = ircfd_pkg::MODE_OFF;
            power_d = 1'b0;
          end else begin
            power_d = 1'b1;
          end
        end
        if (power_d) begin
          case (b3_q[2:0])
            3'd0:    mode_d = ircfd_pkg::MODE_HEAT;
            3'd1:    mode_d = ircfd_pkg::MODE_HEAT_COOL;
            3'd2:    mode_d = ircfd_pkg::MODE_COOL;
            3'd3:    mode_d = ircfd_pkg::MODE_DRY;
            3'd4:    mode_d = ircfd_pkg::MODE_FAN_ONLY;
            default: ;
          endcase
        end
        if (b2_q[7] && b8_q == ircfd_pkg::SWING_BYTE) begin
          swing_d = ~swing_q;
        end
        res_temp = 7'(b3_q[7:4]) + 7'(min_temp_q);
        res_fan = b2_q[1:0];
      end
    end else if (pos == 9'(ircfd_pkg::DIV_A_POS) || pos == 9'(ircfd_pkg::DIV_B_POS)) begin
      if (!(bit_mark_ok && div_ok)) begin
        res_valid = 1'b1;
        res_status = ircfd_pkg::ST_BIT_FAIL;
        phase_d = '0;
      end else begin
        phase_d = phase_q + 9'd1;
      end
    end else begin
      if (!(bit_mark_ok && (one_ok || zero_ok))) begin
        res_valid = 1'b1;
        res_status = ircfd_pkg::ST_BIT_FAIL;
        phase_d = '0;
      end else begin
        phase_d = phase_q + 9'd1;
        acc_d = acc_new;
        if (bit_idx == 3'd7) begin
          case (byte_idx)
            5'd0:    b0_d = acc_new;
            5'd1:    b1_d = acc_new;
            5'd2:    b2_d = acc_new;
            5'd3:    b3_d = acc_new;
            5'd8:    b8_d = acc_new;
            5'd13:   b13_d = acc_new;
            5'd20:   b20_d = acc_new;
            default: ;
          endcase
          if (byte_idx >= 5'd2 && byte_idx <= 5'd12) begin
            xor_lo_d = xor_lo_q ^ acc_new;
          end else if (byte_idx >= 5'd14 && byte_idx <= 5'd19) begin
            xor_hi_d = xor_hi_q ^ acc_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      xor_lo_q <= '0;
      xor_hi_q <= '0;
      mode_q <= ircfd_pkg::MODE_OFF;
      power_q <= 1'b0;
      swing_q <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      xor_lo_q <= xor_lo_d;
      xor_hi_q <= xor_hi_d;
      mode_q <= mode_d;
      power_q <= power_d;
      swing_q <= swing_d;
    end
  end

  // captured bytes, no reset
  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q <= acc_d;
      b0_q <= b0_d;
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b8_q <= b8_d;
      b13_q <= b13_d;
      b20_q <= b20_d;
    end
  end

  // result register
  logic       out_valid_q;
  logic [15:0] out_data_q;
  logic [2:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_data_q <= {2'b00, power_d, swing_d, res_fan, res_temp, mode_d};
      out_user_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

endmodule
